>>> rtl/bpq_pkg.sv
// ----------------------------------------------------------------------------
// Bucket priority queue package
// Shared constants, types and helpers for the bucket priority queue.
// ----------------------------------------------------------------------------
package bpq_pkg;

    localparam int NUM_VERTICES = 64;
    localparam int NUM_BINS     = 63;

    localparam int VERTEX_W = 6;
    localparam int KEY_W    = 6;
    localparam int LINK_W   = 7;
    localparam int MIN_W    = 7;

    localparam logic [LINK_W-1:0]   LINK_NULL = {LINK_W{1'b1}};
    localparam logic [VERTEX_W-1:0] CNT_LAST  = VERTEX_W'(NUM_VERTICES - 1);
    localparam logic [MIN_W-1:0]    MIN_RESET = MIN_W'(NUM_BINS);

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 1;

    typedef logic [VERTEX_W-1:0] vertex_t;
    typedef logic [KEY_W-1:0]    key_t;
    typedef logic [LINK_W-1:0]   link_t;

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_REMOVE  = 2'd1,
        OP_UPDATE  = 2'd2,
        OP_EXTRACT = 2'd3
    } op_t;

    typedef struct packed {
        op_t     op;
        vertex_t vertex;
        key_t    new_key;
        key_t    old_key;
    } queue_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REM_RD,
        ST_REM_WR,
        ST_INS_RD,
        ST_INS_WR,
        ST_INS_FIX,
        ST_EXT_TIGHT,
        ST_EXT_HEAD,
        ST_EXT_WALK
    } state_t;

    // A stored link at or above the vertex count stands for the end of a list.
    function automatic logic link_is_null(input link_t link);
        return link >= LINK_W'(NUM_VERTICES);
    endfunction

endpackage

>>> rtl/bpq_front.sv
// ----------------------------------------------------------------------------
// Bucket priority queue front end
// Accepts input beats, decodes the operation and queues it for the back end.
// ----------------------------------------------------------------------------
module bpq_front
    import bpq_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // vertex, new_key, old_key, zero fill
    input  logic [S_TUSER_W-1:0] s_tuser,  // kind
    output logic                 q_valid,
    output queue_item_t          q_item,
    input  logic                 q_pop
);

    queue_item_t             entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0]     count_reg, count_next;
    queue_item_t             item_in;
    logic                    push;

    always_comb begin
        item_in.vertex  = s_tdata[VERTEX_W-1:0];
        item_in.new_key = s_tdata[VERTEX_W+KEY_W-1:VERTEX_W];
        item_in.old_key = s_tdata[VERTEX_W+2*KEY_W-1:VERTEX_W+KEY_W];
        item_in.op      = op_t'(s_tuser);
    end

    assign s_tready = (count_reg != QUEUE_CW'(QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign q_item   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push  ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && q_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

>>> rtl/bpq_back.sv
// ----------------------------------------------------------------------------
// Bucket priority queue back end
// Sequences the list memories for insert, remove, update and extraction.
// ----------------------------------------------------------------------------
module bpq_back
    import bpq_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    input  queue_item_t          q_item,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // out_vertex, min_key, zero fill
    output logic                 m_tlast,
    output logic [M_TUSER_W-1:0] m_tuser   // empty_res
);

    // List memories. Bucket heads are only meaningful where occ_reg is set.
    vertex_t head_mem [NUM_BINS+1];
    link_t   prev_mem [NUM_VERTICES];
    link_t   next_mem [NUM_VERTICES];

    state_t               state_reg, state_next;
    queue_item_t          cur_reg, cur_next;
    logic [NUM_BINS:0]    occ_reg, occ_next;
    logic [MIN_W-1:0]     min_reg, min_next;
    key_t                 max_reg, max_next;
    vertex_t              walk_reg, walk_next;
    vertex_t              cnt_reg, cnt_next;
    link_t                pend_reg, pend_next;

    vertex_t              head_rd_reg;
    link_t                prev_rd_reg, next_rd_reg;

    logic                 out_valid_reg, out_valid_next;
    vertex_t              out_vertex_reg;
    logic [MIN_W-1:0]     out_min_reg;
    logic                 out_last_reg, out_empty_reg;

    logic                 head_re, head_we, prev_re, prev_we, next_re, next_we;
    key_t                 head_raddr, head_waddr;
    vertex_t              head_wdata;
    vertex_t              prev_raddr, prev_waddr, next_raddr, next_waddr;
    link_t                prev_wdata, next_wdata;

    logic                 out_load, out_last_in, out_empty_in;
    vertex_t              out_vertex_in;
    logic                 out_free;

    logic                 min_in_range, min_le_max, min_occ;
    logic                 tight_step, tight_empty;
    key_t                 min_idx;
    link_t                ins_head, walk_nx;
    logic                 walk_fin;

    assign out_free     = !out_valid_reg || m_tready;
    assign min_in_range = (min_reg <= MIN_RESET);
    assign min_le_max   = (min_reg <= {1'b0, max_reg});
    assign min_idx      = min_reg[KEY_W-1:0];
    assign min_occ      = occ_reg[min_idx];
    assign tight_step   = min_le_max && min_in_range && !min_occ;
    assign tight_empty  = !min_le_max || !min_in_range || !min_occ;
    assign ins_head     = occ_reg[cur_reg.new_key] ? {1'b0, head_rd_reg} : LINK_NULL;
    assign walk_nx      = next_rd_reg;
    assign walk_fin     = link_is_null(walk_nx) || (cnt_reg == CNT_LAST);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    unique case (q_item.op)
                        OP_INSERT:  state_next = ST_INS_RD;
                        OP_EXTRACT: state_next = ST_EXT_TIGHT;
                        default:    state_next = ST_REM_RD;
                    endcase
                end
            end
            ST_REM_RD:  state_next = ST_REM_WR;
            ST_REM_WR:  state_next = (cur_reg.op == OP_UPDATE) ? ST_INS_RD : ST_IDLE;
            ST_INS_RD:  state_next = ST_INS_WR;
            ST_INS_WR:  state_next = link_is_null(ins_head) ? ST_IDLE : ST_INS_FIX;
            ST_INS_FIX: state_next = ST_IDLE;
            ST_EXT_TIGHT: begin
                if (!tight_step) begin
                    if (!tight_empty) begin
                        state_next = ST_EXT_HEAD;
                    end else if (out_free) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EXT_HEAD: state_next = ST_EXT_WALK;
            ST_EXT_WALK: begin
                if (out_free && walk_fin) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath controls.
    always_comb begin
        q_pop         = 1'b0;
        cur_next      = cur_reg;
        occ_next      = occ_reg;
        min_next      = min_reg;
        max_next      = max_reg;
        walk_next     = walk_reg;
        cnt_next      = cnt_reg;
        pend_next     = pend_reg;
        head_re       = 1'b0;
        head_raddr    = cur_reg.new_key;
        head_we       = 1'b0;
        head_waddr    = cur_reg.new_key;
        head_wdata    = cur_reg.vertex;
        prev_re       = 1'b0;
        prev_raddr    = cur_reg.vertex;
        prev_we       = 1'b0;
        prev_waddr    = cur_reg.vertex;
        prev_wdata    = LINK_NULL;
        next_re       = 1'b0;
        next_raddr    = cur_reg.vertex;
        next_we       = 1'b0;
        next_waddr    = cur_reg.vertex;
        next_wdata    = LINK_NULL;
        out_load      = 1'b0;
        out_vertex_in = walk_reg;
        out_last_in   = 1'b0;
        out_empty_in  = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop    = 1'b1;
                    cur_next = q_item;
                end
            end
            ST_REM_RD: begin
                prev_re = 1'b1;
                next_re = 1'b1;
            end
            ST_REM_WR: begin
                if (link_is_null(prev_rd_reg)) begin
                    // Vertex was at the head: its successor becomes the head.
                    occ_next[cur_reg.old_key] = !link_is_null(next_rd_reg);
                    head_we    = !link_is_null(next_rd_reg);
                    head_waddr = cur_reg.old_key;
                    head_wdata = next_rd_reg[VERTEX_W-1:0];
                    prev_wdata = LINK_NULL;
                end else begin
                    next_we    = 1'b1;
                    next_waddr = prev_rd_reg[VERTEX_W-1:0];
                    next_wdata = link_is_null(next_rd_reg) ? LINK_NULL : next_rd_reg;
                    prev_wdata = prev_rd_reg;
                end
                prev_we    = !link_is_null(next_rd_reg);
                prev_waddr = next_rd_reg[VERTEX_W-1:0];
            end
            ST_INS_RD: begin
                head_re = 1'b1;
            end
            ST_INS_WR: begin
                prev_we    = 1'b1;
                prev_wdata = LINK_NULL;
                next_we    = 1'b1;
                next_wdata = ins_head;
                head_we    = 1'b1;
                occ_next[cur_reg.new_key] = 1'b1;
                pend_next  = ins_head;
                if ({1'b0, cur_reg.new_key} < min_reg) begin
                    min_next = {1'b0, cur_reg.new_key};
                end
                if (cur_reg.new_key > max_reg) begin
                    max_next = cur_reg.new_key;
                end
            end
            ST_INS_FIX: begin
                prev_we    = 1'b1;
                prev_waddr = pend_reg[VERTEX_W-1:0];
                prev_wdata = {1'b0, cur_reg.vertex};
            end
            ST_EXT_TIGHT: begin
                head_raddr = min_idx;
                if (tight_step) begin
                    min_next = min_reg + 1'b1;
                end else if (!tight_empty) begin
                    head_re = 1'b1;
                end else if (out_free) begin
                    out_load      = 1'b1;
                    out_vertex_in = '0;
                    out_last_in   = 1'b1;
                    out_empty_in  = 1'b1;
                end
            end
            ST_EXT_HEAD: begin
                walk_next  = head_rd_reg;
                next_re    = 1'b1;
                next_raddr = head_rd_reg;
                cnt_next   = '0;
            end
            ST_EXT_WALK: begin
                if (out_free) begin
                    out_load    = 1'b1;
                    out_last_in = walk_fin;
                    if (walk_fin) begin
                        // Emptying the bucket only drops its head; links stay.
                        occ_next[min_idx] = 1'b0;
                    end else begin
                        walk_next  = walk_nx[VERTEX_W-1:0];
                        next_re    = 1'b1;
                        next_raddr = walk_nx[VERTEX_W-1:0];
                        cnt_next   = cnt_reg + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign out_valid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            occ_reg       <= '0;
            min_reg       <= MIN_RESET;
            max_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg  <= cur_next;
        walk_reg <= walk_next;
        cnt_reg  <= cnt_next;
        pend_reg <= pend_next;
        if (out_load) begin
            out_vertex_reg <= out_vertex_in;
            out_min_reg    <= min_reg;
            out_last_reg   <= out_last_in;
            out_empty_reg  <= out_empty_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (head_we) begin
            head_mem[head_waddr] <= head_wdata;
        end
        if (head_re) begin
            head_rd_reg <= head_mem[head_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (prev_we) begin
            prev_mem[prev_waddr] <= prev_wdata;
        end
        if (prev_re) begin
            prev_rd_reg <= prev_mem[prev_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (next_we) begin
            next_mem[next_waddr] <= next_wdata;
        end
        if (next_re) begin
            next_rd_reg <= next_mem[next_raddr];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-VERTEX_W-MIN_W){1'b0}}, out_min_reg, out_vertex_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_empty_reg;

    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_empty_reg) |-> out_last_reg)
        else $error("empty result without last marker");

    a_insert_marks_bucket: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_INS_WR) |=> occ_reg[$past(cur_reg.new_key)])
        else $error("bucket not marked occupied after insert");

    a_tighten_monotone: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXT_TIGHT) |=> (min_reg >= $past(min_reg)))
        else $error("minimum moved backward while tightening");

    a_extract_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXT_WALK && out_free && walk_fin)
            |=> !occ_reg[$past(min_reg[KEY_W-1:0])])
        else $error("extracted bucket still marked occupied");

endmodule

>>> rtl/bucket_priority_queue.sv
// ----------------------------------------------------------------------------
// Bucket priority queue
// Vertex bucket queue with insert, remove, update and extract-minimum.
// ----------------------------------------------------------------------------
// Input beats land in a four-deep queue and are executed one at a time by a
// sequencer over three single-port list memories with registered reads. Each
// operation is dispatched from idle. Insert reads the bucket head and writes
// the links, then fixes the back link of the old head if there was one; remove
// reads and rewrites the neighbour links; update is a remove, then an insert.
// Extraction skips empty buckets one per cycle while advancing the minimum,
// fetches the head, then emits one vertex per cycle, as each next link comes
// from the next-link memory read of the cycle before. Results leave through
// an output register, so the walk stalls only when downstream holds tready
// low. Bucket occupancy is in flip-flops cleared by reset; no pass is needed.
module bucket_priority_queue
    import bpq_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // vertex, new_key, old_key, zero fill
    input  logic [S_TUSER_W-1:0] s_tuser,  // kind
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // out_vertex, min_key, zero fill
    output logic                 m_tlast,
    output logic [M_TUSER_W-1:0] m_tuser   // empty_res
);

    logic        q_valid;
    logic        q_pop;
    queue_item_t q_item;

    bpq_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    bpq_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
